/* src/ranked_stream_lock_arbiter_top_macros.svh */
// assertion macros for the lock arbiter
`ifndef RANKED_STREAM_LOCK_ARBITER_TOP_MACROS_SVH
`define RANKED_STREAM_LOCK_ARBITER_TOP_MACROS_SVH

// same-cycle implication
`define RSLA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rsla_pkg.sv */
package rsla_pkg;

    localparam int NumStreams = 16;
    localparam int StackDepth = 8;
    localparam int NumRanks   = 4;
    localparam int StreamW    = $clog2(NumStreams);
    localparam int SlotW      = $clog2(StackDepth);
    localparam int DepthW     = $clog2(StackDepth + 1);
    localparam int AddrW      = StreamW + SlotW;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_LOCK   = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    localparam logic [2:0] RANK_NONE   = 3'd0;
    localparam logic [2:0] RANK_BRANCH = 3'd1;
    localparam logic [2:0] RANK_SCC    = 3'd4;

    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_NOT_SCHED   = 3'd1;
    localparam logic [2:0] ERR_ORDER       = 3'd2;
    localparam logic [2:0] ERR_FOREIGN     = 3'd3;
    localparam logic [2:0] ERR_UNLOCK_EMPTY = 3'd4;
    localparam logic [2:0] ERR_NOT_TOP     = 3'd5;
    localparam logic [2:0] ERR_FULL        = 3'd6;

    typedef struct packed {
        logic       action;
        logic [3:0] stream_id;
        logic [1:0] lock_op;
        logic [2:0] dep_rank;
    } t_req;

    typedef struct packed {
        logic       schedulable;
        logic [2:0] error_code;
        logic [2:0] top_rank;
        logic [3:0] lock_depth;
        logic       exclusive_valid;
        logic [3:0] exclusive_stream;
    } t_rsp;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

/* src/ranked_stream_lock_arbiter_top.sv */
// channel | dir | handshake                  | payload
// request | in  | i_req_valid / o_req_ready  | i_req (t_req)
// result  | out | o_rsp_valid / i_rsp_ready  | o_rsp (t_rsp)
// each request first reads the stack memory (two read ports, top and entry below
// it), then decides, writes back and loads the result register
// a new request is taken while idle, once the result register is empty or being drained
// synchronous active-low reset clears depths, hold counts and the exclusive holder;
// stack memory and rank owners need no clearing
module ranked_stream_lock_arbiter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rsla_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output rsla_pkg::t_rsp o_rsp
);
    import rsla_pkg::*;

    logic [2:0]        mem_stack [NumStreams*StackDepth];
    logic [2:0]        r_rd_top;
    logic [2:0]        r_rd_below;

    logic [DepthW-1:0] r_depth [NumStreams];
    logic [3:0]        r_cnt   [NumRanks];
    logic [StreamW-1:0] r_owner [NumRanks];
    logic              r_exf;
    logic [StreamW-1:0] r_exo;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp, n_rsp;
    logic   r_out_valid;

    logic accept;
    logic [DepthW-1:0] in_depth;

    assign accept   = i_req_valid && o_req_ready;
    assign in_depth = r_depth[i_req.stream_id];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the fsm
    always_comb begin
        unique case (r_state)
            ST_IDLE: o_req_ready = !r_out_valid || i_rsp_ready;
            default: o_req_ready = 1'b0;
        endcase
    end

    // stack memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_top   <= mem_stack[{i_req.stream_id, SlotW'(in_depth - DepthW'(1))}];
            r_rd_below <= mem_stack[{i_req.stream_id, SlotW'(in_depth - DepthW'(2))}];
        end
    end

    // execute stage
    logic [DepthW-1:0] d;
    logic [2:0]        top, newtop, rr;
    logic [1:0]        ri, ti;
    logic [StreamW-1:0] s;
    logic              valid_req, sched, do_lock, do_unlock;
    logic [2:0]        err;
    logic              higher_held;
    logic [3:0]        cnt_dec1, cnt_dec4;
    logic              n_exf;
    logic [StreamW-1:0] n_exo;
    logic [DepthW-1:0] n_depth;
    logic [2:0]        n_top;

    always_comb begin
        s      = r_req.stream_id;
        rr     = r_req.dep_rank;
        d      = r_depth[s];
        top    = (d == '0) ? RANK_NONE : r_rd_top;
        newtop = (d <= DepthW'(1)) ? RANK_NONE : r_rd_below;
        ri     = 2'(rr - 3'd1);
        ti     = 2'(top - 3'd1);
        valid_req = (rr <= 3'(NumRanks)) && (r_req.lock_op != OP_BAD)
                    && !(r_req.lock_op == OP_LOCK && rr == RANK_NONE);
        higher_held = 1'b0;
        for (int k = 1; k <= NumRanks; k++) begin
            if (k > int'(rr) && r_cnt[k-1] != '0) higher_held = 1'b1;
        end

        if (rr != RANK_NONE && top > rr)             err = ERR_ORDER;
        else if (r_exf && r_exo == s)                err = ERR_OK;
        else if (r_exf)                              err = ERR_NOT_SCHED;
        else if (r_req.lock_op != OP_LOCK)           err = ERR_OK;
        else if (r_cnt[ri] != '0)                    err = (r_owner[ri] == s) ? ERR_OK
                                                                             : ERR_NOT_SCHED;
        else if ((rr == RANK_BRANCH || rr == RANK_SCC) && higher_held) err = ERR_NOT_SCHED;
        else                                         err = ERR_OK;
        if (!valid_req) err = ERR_NOT_SCHED;
        sched = (err == ERR_OK);

        do_lock   = 1'b0;
        do_unlock = 1'b0;
        n_exf   = r_exf;
        n_exo   = r_exo;
        n_depth = d;
        n_top   = top;
        cnt_dec1 = r_cnt[0];
        cnt_dec4 = r_cnt[NumRanks-1];

        if (sched && r_req.action) begin
            if (r_req.lock_op == OP_LOCK) begin
                if (r_cnt[ri] != '0 && (top != rr || r_owner[ri] != s)) err = ERR_FOREIGN;
                else if (d >= DepthW'(StackDepth))                     err = ERR_FULL;
                else begin
                    do_lock = 1'b1;
                    n_depth = d + DepthW'(1);
                    n_top   = rr;
                    if (rr == RANK_BRANCH || rr == RANK_SCC) begin
                        n_exf = 1'b1;
                        n_exo = s;
                    end
                end
            end else if (r_req.lock_op == OP_UNLOCK) begin
                if (d == '0)                               err = ERR_UNLOCK_EMPTY;
                else if (rr != RANK_NONE && rr != top)     err = ERR_NOT_TOP;
                else if (top == RANK_NONE || top > 3'(NumRanks)) err = ERR_UNLOCK_EMPTY;
                else begin
                    do_unlock = 1'b1;
                    n_depth = d - DepthW'(1);
                    n_top   = newtop;
                    if (top == RANK_BRANCH && r_cnt[0] != '0) cnt_dec1 = r_cnt[0] - 4'd1;
                    if (top == RANK_SCC && r_cnt[NumRanks-1] != '0)
                        cnt_dec4 = r_cnt[NumRanks-1] - 4'd1;
                    // rescan own held exclusive ranks at or below the new top
                    n_exf = (newtop >= RANK_BRANCH && cnt_dec1 != '0 && r_owner[0] == s)
                         || (newtop >= RANK_SCC && cnt_dec4 != '0 && r_owner[NumRanks-1] == s);
                    n_exo = n_exf ? s : '0;
                end
            end
        end

        n_rsp.schedulable      = sched;
        n_rsp.error_code       = err;
        n_rsp.top_rank         = n_top;
        n_rsp.lock_depth       = 4'(n_depth);
        n_rsp.exclusive_valid  = n_exf;
        n_rsp.exclusive_stream = n_exf ? 4'(n_exo) : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC && do_lock) begin
            mem_stack[{s, SlotW'(d)}] <= rr;
            r_owner[ri] <= s;
        end
        if (accept) r_req <= i_req;
        if (r_state == ST_EXEC) r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_exf       <= 1'b0;
            r_exo       <= '0;
            for (int i = 0; i < NumStreams; i++) r_depth[i] <= '0;
            for (int i = 0; i < NumRanks; i++)   r_cnt[i]   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC)       r_out_valid <= 1'b1;
            else if (i_rsp_ready)         r_out_valid <= 1'b0;
            if (r_state == ST_EXEC) begin
                r_exf      <= n_exf;
                r_exo      <= n_exo;
                r_depth[s] <= n_depth;
                if (do_lock) r_cnt[ri] <= r_cnt[ri] + 4'd1;
                if (do_unlock) begin
                    r_cnt[0]          <= cnt_dec1;
                    r_cnt[NumRanks-1] <= cnt_dec4;
                    if (top != RANK_BRANCH && top != RANK_SCC && r_cnt[ti] != '0)
                        r_cnt[ti] <= r_cnt[ti] - 4'd1;
                end
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

`include "ranked_stream_lock_arbiter_top_macros.svh"
    `RSLA_ASSERT_NOW(a_exo_clear, !r_exf, r_exo == '0, "exclusive owner set without flag")
    `RSLA_ASSERT_NOW(a_depth_max, r_state == ST_EXEC, d <= DepthW'(StackDepth), "stack overrun")
    `RSLA_ASSERT_NEXT(a_accept_exec, accept, r_state == ST_EXEC, "accepted request not executed")
    `RSLA_ASSERT_NEXT(a_exec_out, r_state == ST_EXEC, r_out_valid, "result not loaded")

endmodule
